>>> rtl/pcc_pkg.sv
// Shared types and constants for the polygon convexity checker.
// No dependencies; compiled first.
package pcc_pkg;

    localparam int unsigned NUM_EDGES = 4;
    localparam int unsigned NUM_CROSS = 3;

    localparam logic [2:0] VERT_SAT  = 3'd4;
    localparam logic [2:0] VERT_TRI  = 3'd3;
    localparam logic [2:0] VERT_TWO  = 3'd2;
    localparam logic [1:0] EDGE_SAT  = 2'd3;

    // Sign flag positions in the accumulator.
    localparam int unsigned SGN_NEG = 0;
    localparam int unsigned SGN_POS = 1;

    typedef struct packed {
        logic [NUM_CROSS-1:0] cross_en;
        logic                 last;
        logic                 exists;
        logic                 triangle;
        logic                 many;
    } pcc_ctrl_t;

endpackage

>>> rtl/pcc_vertex_if.sv
// Vertex channel: valid/ready handshake carrying one vertex item.
// Depends on nothing.
interface pcc_vertex_if #(
    parameter int COORD_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] vx;
    logic signed [COORD_WIDTH-1:0] vy;
    logic                          last;

    modport source (output valid, output vx, output vy, output last, input ready);
    modport sink   (input valid, input vx, input vy, input last, output ready);
endinterface

>>> rtl/pcc_result_if.sv
// Result channel: valid/ready handshake carrying the exists/convex flags.
// Depends on nothing.
interface pcc_result_if;
    logic valid;
    logic ready;
    logic exists;
    logic convex;

    modport source (output valid, output exists, output convex, input ready);
    modport sink   (input valid, input exists, input convex, output ready);
endinterface

>>> rtl/pcc_fifo.sv
// Small register queue between the front and back ends.
// Depends on nothing.
module pcc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end
endmodule

>>> rtl/pcc_front.sv
// Front end: accepts vertices, tracks first/second/older/prev vertices and
// edge counts, and queues edge vectors plus control. Uses pcc_pkg, pcc_vertex_if.
module pcc_front #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    pcc_vertex_if.sink                             vertex,
    output logic                                   push_valid,
    input  logic                                   push_ready,
    output pcc_pkg::pcc_ctrl_t                     push_ctrl,
    output logic [pcc_pkg::NUM_EDGES*2*(COORD_WIDTH+1)-1:0] push_edges
);
    import pcc_pkg::*;

    localparam int DW = COORD_WIDTH + 1;

    logic signed [COORD_WIDTH-1:0] first_x_reg, first_y_reg;
    logic signed [COORD_WIDTH-1:0] second_x_reg, second_y_reg;
    logic signed [COORD_WIDTH-1:0] older_x_reg, older_y_reg;
    logic signed [COORD_WIDTH-1:0] prev_x_reg, prev_y_reg;
    logic [2:0]                    count_reg;
    logic [1:0]                    dist_reg;

    logic [2:0]                    count_next;
    logic [1:0]                    dist_a;
    logic [1:0]                    dist_b;
    logic                          cur_ne_prev;
    logic                          close_ne;
    logic signed [COORD_WIDTH-1:0] first_ex, first_ey;
    logic                          accept;
    logic signed [DW-1:0]          ex [NUM_EDGES];
    logic signed [DW-1:0]          ey [NUM_EDGES];

    function automatic logic signed [DW-1:0] sdiff(
        input logic signed [COORD_WIDTH-1:0] a,
        input logic signed [COORD_WIDTH-1:0] b
    );
        sdiff = DW'(a) - DW'(b);
    endfunction

    assign count_next  = (count_reg == VERT_SAT) ? VERT_SAT : count_reg + 3'd1;
    assign cur_ne_prev = (vertex.vx != prev_x_reg) || (vertex.vy != prev_y_reg);
    assign dist_a      = ((count_reg != '0) && cur_ne_prev && (dist_reg != EDGE_SAT)) ?
                         dist_reg + 2'd1 : dist_reg;
    assign first_ex    = (count_reg == '0) ? vertex.vx : first_x_reg;
    assign first_ey    = (count_reg == '0) ? vertex.vy : first_y_reg;
    assign close_ne    = (vertex.vx != first_ex) || (vertex.vy != first_ey);
    assign dist_b      = (close_ne && (dist_a != EDGE_SAT)) ? dist_a + 2'd1 : dist_a;

    // Edges: previous, current, closing, first.
    assign ex[0] = sdiff(prev_x_reg, older_x_reg);
    assign ey[0] = sdiff(prev_y_reg, older_y_reg);
    assign ex[1] = sdiff(vertex.vx, prev_x_reg);
    assign ey[1] = sdiff(vertex.vy, prev_y_reg);
    assign ex[2] = sdiff(first_x_reg, vertex.vx);
    assign ey[2] = sdiff(first_y_reg, vertex.vy);
    assign ex[3] = sdiff(second_x_reg, first_x_reg);
    assign ey[3] = sdiff(second_y_reg, first_y_reg);

    always_comb
    begin
        for (int k = 0; k < NUM_EDGES; k++)
        begin
            push_edges[k*2*DW +: 2*DW] = {ex[k], ey[k]};
        end
    end

    always_comb
    begin
        push_ctrl.cross_en[0] = (count_reg >= VERT_TWO);
        push_ctrl.cross_en[1] = vertex.last && (count_next >= VERT_TRI);
        push_ctrl.cross_en[2] = vertex.last && (count_next >= VERT_TRI);
        push_ctrl.last        = vertex.last;
        push_ctrl.exists      = (count_next >= VERT_TRI) && (dist_b == EDGE_SAT);
        push_ctrl.triangle    = (count_next == VERT_TRI);
        push_ctrl.many        = (count_next == VERT_SAT);
    end

    assign vertex.ready = push_ready;
    assign push_valid   = vertex.valid && ((count_reg >= VERT_TWO) || vertex.last);
    assign accept       = vertex.valid && vertex.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_x_reg  <= '0;
            first_y_reg  <= '0;
            second_x_reg <= '0;
            second_y_reg <= '0;
            older_x_reg  <= '0;
            older_y_reg  <= '0;
            prev_x_reg   <= '0;
            prev_y_reg   <= '0;
            count_reg    <= '0;
            dist_reg     <= '0;
        end
        else if (accept)
        begin
            if (vertex.last)
            begin
                first_x_reg  <= '0;
                first_y_reg  <= '0;
                second_x_reg <= '0;
                second_y_reg <= '0;
                older_x_reg  <= '0;
                older_y_reg  <= '0;
                prev_x_reg   <= '0;
                prev_y_reg   <= '0;
                count_reg    <= '0;
                dist_reg     <= '0;
            end
            else
            begin
                if (count_reg == '0)
                begin
                    first_x_reg <= vertex.vx;
                    first_y_reg <= vertex.vy;
                end
                if (count_reg == 3'd1)
                begin
                    second_x_reg <= vertex.vx;
                    second_y_reg <= vertex.vy;
                end
                older_x_reg <= prev_x_reg;
                older_y_reg <= prev_y_reg;
                prev_x_reg  <= vertex.vx;
                prev_y_reg  <= vertex.vy;
                count_reg   <= count_next;
                dist_reg    <= dist_a;
            end
        end
    end
endmodule

>>> rtl/pcc_back.sv
// Back end: cross products of adjacent edges, sign accumulation and the
// result register. Uses pcc_pkg, pcc_result_if.
module pcc_back #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   pop_valid,
    output logic                                   pop_ready,
    input  pcc_pkg::pcc_ctrl_t                     pop_ctrl,
    input  logic [pcc_pkg::NUM_EDGES*2*(COORD_WIDTH+1)-1:0] pop_edges,
    pcc_result_if.source                           result
);
    import pcc_pkg::*;

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;

    logic signed [DW-1:0] ex [NUM_EDGES];
    logic signed [DW-1:0] ey [NUM_EDGES];

    logic                 s1_valid_reg;
    pcc_ctrl_t            s1_ctrl_reg;
    logic signed [PW-1:0] prod_a_reg [NUM_CROSS];
    logic signed [PW-1:0] prod_b_reg [NUM_CROSS];

    logic [1:0]           sign_reg;
    logic [1:0]           sign_next;
    logic                 res_valid_reg;
    logic                 res_exists_reg;
    logic                 res_convex_reg;

    logic                 out_free;
    logic                 s1_done;
    logic signed [PW:0]   diff [NUM_CROSS];
    logic                 convex_next;

    always_comb
    begin
        for (int k = 0; k < NUM_EDGES; k++)
        begin
            ex[k] = pop_edges[k*2*DW + DW +: DW];
            ey[k] = pop_edges[k*2*DW +: DW];
        end
    end

    assign out_free  = !res_valid_reg || result.ready;
    assign s1_done   = s1_valid_reg && (!s1_ctrl_reg.last || out_free);
    assign pop_ready = !s1_valid_reg || s1_done;

    always_ff @(posedge clk)
    begin
        if (pop_valid && pop_ready)
        begin
            s1_ctrl_reg <= pop_ctrl;
            for (int k = 0; k < NUM_CROSS; k++)
            begin
                prod_a_reg[k] <= ex[k] * ey[k+1];
                prod_b_reg[k] <= ey[k] * ex[k+1];
            end
        end
    end

    always_comb
    begin
        sign_next = sign_reg;
        for (int k = 0; k < NUM_CROSS; k++)
        begin
            diff[k] = (PW+1)'(prod_a_reg[k]) - (PW+1)'(prod_b_reg[k]);
            if (s1_ctrl_reg.cross_en[k])
            begin
                if (diff[k][PW])
                begin
                    sign_next[SGN_NEG] = 1'b1;
                end
                else if (diff[k] != '0)
                begin
                    sign_next[SGN_POS] = 1'b1;
                end
            end
        end
        convex_next = s1_ctrl_reg.triangle ||
                      (s1_ctrl_reg.many && (sign_next != 2'b00) && (sign_next != 2'b11));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            sign_reg       <= '0;
            res_valid_reg  <= 1'b0;
            res_exists_reg <= 1'b0;
            res_convex_reg <= 1'b0;
        end
        else
        begin
            if (pop_ready)
            begin
                s1_valid_reg <= pop_valid;
            end
            if (s1_done)
            begin
                sign_reg <= s1_ctrl_reg.last ? 2'b00 : sign_next;
            end
            if (s1_done && s1_ctrl_reg.last)
            begin
                res_valid_reg  <= 1'b1;
                res_exists_reg <= s1_ctrl_reg.exists;
                res_convex_reg <= convex_next;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    assign result.valid  = res_valid_reg;
    assign result.exists = res_exists_reg;
    assign result.convex = res_convex_reg;
endmodule

>>> rtl/polygon_convexity_check_top.sv
// Polygon convexity checker: takes one vertex per cycle while the queue has
// room and returns one exists/convex result per polygon. The result is
// registered after the closing vertex is accepted: the queue entry is written
// at the accepting edge, then the registered multiplier stage takes it and
// then the result register. Six (COORD_WIDTH+1)-bit signed multipliers work in
// parallel. A two-entry queue decouples vertex intake from the back end, so
// intake continues while a result waits on the output until the queue fills.
// Depends on pcc_pkg, pcc_vertex_if, pcc_result_if, pcc_fifo, pcc_front, pcc_back.
module polygon_convexity_check_top #(
    parameter int COORD_WIDTH = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    pcc_vertex_if.sink    vertex,
    pcc_result_if.source  result
);
    import pcc_pkg::*;

    localparam int EW = NUM_EDGES * 2 * (COORD_WIDTH + 1);
    localparam int QW = $bits(pcc_ctrl_t) + EW;

    logic            push_valid;
    logic            push_ready;
    pcc_ctrl_t       push_ctrl;
    logic [EW-1:0]   push_edges;
    logic            pop_valid;
    logic            pop_ready;
    logic [QW-1:0]   pop_data;
    pcc_ctrl_t       pop_ctrl;
    logic [EW-1:0]   pop_edges;

    assign pop_ctrl  = pop_data[QW-1:EW];
    assign pop_edges = pop_data[EW-1:0];

    pcc_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .vertex     (vertex),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_ctrl  (push_ctrl),
        .push_edges (push_edges)
    );

    pcc_fifo #(
        .WIDTH (QW),
        .DEPTH (2)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_ctrl, push_edges}),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    pcc_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_ctrl  (pop_ctrl),
        .pop_edges (pop_edges),
        .result    (result)
    );
endmodule
